/* design/point_cluster_statistics_top_assert.svh */
// Assertion macros shared by the point cluster statistics RTL.
`ifndef POINT_CLUSTER_STATISTICS_TOP_ASSERT_SVH
`define POINT_CLUSTER_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PCS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("point cluster assertion failed");

// Next-cycle implication.
`define PCS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("point cluster assertion failed");

`endif

/* design/pcs_pkg.sv */
// Package with defaults, codes and state types of the point cluster statistics block.
package pcs_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OP_BITS        = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_LINK   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        DV_X   = 2'd0,
        DV_Y   = 2'd1,
        DV_Z   = 2'd2,
        DV_DEV = 2'd3
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCMP,
        ST_APPLY,
        ST_RRD,
        ST_RWR,
        ST_CENT,
        ST_DIV,
        ST_DEND,
        ST_WRD,
        ST_WMUL,
        ST_WEND,
        ST_DONE
    } t_state;

endpackage

/* design/point_cluster_statistics_top.sv */
// Point cluster statistics: point set store, running sums, centroid and distance statistics.
//
//  channel  dir  handshake                     payload
//  -------  ---  ----------------------------  ------------------------------------------
//  s        in   i_s_tvalid / o_s_tready       tuser: op; tdata: point_x, point_y, point_z
//  m        out  o_m_tvalid / i_m_tready       tdata: count, centroid, statistics, flags
//
//  A request searches the held points, runs three centroid divides, walks the stored
//  points and the query point for distances and ends with a mean divide (an empty set
//  skips search and divides). A single 25x25 squarer, used six times per stored point,
//  and a DVW-bit (58, the dispersion width) divider at one quotient bit per cycle serve.
//  Reset (i_rst_n low at a clock edge) empties the set and drops a pending result;
//  the point memory itself is not cleared.
//  o_s_tready is high only while the sequencer is idle; a finished result waits in the
//  output register while the next request is already taken and worked on.
module point_cluster_statistics_top #(
    parameter int CAPACITY   = pcs_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = pcs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = pcs_pkg::FRAC_BITS_DEF,
    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int CEW   = COORD_BITS + FRAC_BITS,
    localparam int MW    = CEW + 1,
    localparam int DW    = 2 * MW,
    localparam int DISPW = DW + IW,
    localparam int NW    = 2 * COORD_BITS + 2,
    localparam int PW    = 3 * COORD_BITS,
    localparam int INB   = ((PW + 7) / 8) * 8,
    localparam int OUTW  = CW + 3 * CEW + DISPW + 3 * DW + NW + DW + 2,
    localparam int OUTB  = ((OUTW + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [INB-1:0]              i_s_tdata,  // point_x, point_y, point_z
    input  logic [pcs_pkg::OP_BITS-1:0] i_s_tuser,  // op
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // point_count, center_x, center_y, center_z, dispersion, deviation,
    // min_center_dist, max_center_dist, nearest_dist, query_center_dist, contained, changed
    output logic [OUTB-1:0]             o_m_tdata
);

    localparam int SW   = COORD_BITS + IW;
    localparam int NUMW = SW + FRAC_BITS;
    localparam int DVW  = DISPW;
    localparam int DCW  = $clog2(DVW + 1);

    pcs_pkg::t_state   r_state, n_state;
    pcs_pkg::t_op      r_op;
    pcs_pkg::t_div_sel r_dsel;

    // Point memory, one entry per held point, packed {z, y, x}.
    logic [PW-1:0] r_mem [CAPACITY];
    logic [PW-1:0] r_rd;
    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [PW-1:0] w_wdata;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [CW-1:0]        r_count;
    logic signed [SW-1:0] r_sx, r_sy, r_sz;
    logic [IW-1:0]        r_i, r_idx;
    logic                 r_found, r_changed, r_qpass;

    // Divider
    logic [DVW-1:0] r_dnum;
    logic [CW-1:0]  r_drem;
    logic [DCW-1:0] r_dcnt;
    logic           r_dneg;

    // Squarer and accumulators
    logic [2:0]     r_k;
    logic [DW-1:0]  r_prod, r_dacc;
    logic [NW-1:0]  r_eacc;

    logic signed [CEW-1:0] r_cx, r_cy, r_cz;
    logic [DISPW-1:0] r_disp;
    logic [DW-1:0]    r_dev, r_mn, r_mx, r_qd;
    logic [NW-1:0]    r_near;

    logic            r_m_valid;
    logic [OUTB-1:0] r_mdata;

    // Combinational helpers
    logic                  w_match, w_last, w_link_ok;
    logic signed [SW-1:0]  w_sum_sel;
    logic signed [NUMW-1:0] w_num;
    logic [NUMW-1:0]       w_mag;
    logic [CW:0]           w_trial;
    logic                  w_ge;
    logic [CEW-1:0]        w_qadj;
    logic signed [CEW-1:0] w_cent;
    logic [PW-1:0]         w_src;
    logic signed [COORD_BITS-1:0] w_sc, w_pc;
    logic signed [CEW-1:0] w_cc;
    logic signed [MW-1:0]  w_diff;
    logic [MW-1:0]         w_amag;
    logic [NW-1:0]         w_e;
    logic                  w_contained;

    assign o_s_tready = (r_state == pcs_pkg::ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_mdata;

    assign w_match   = (r_rd == {r_pz, r_py, r_px});
    assign w_last    = ((CW'(r_i) + CW'(1)) == r_count);
    assign w_link_ok = !r_found && (r_count < CW'(CAPACITY));

    // Select the sum for the centroid divide in progress and take its magnitude.
    always_comb begin
        case (r_dsel)
            pcs_pkg::DV_X: w_sum_sel = r_sx;
            pcs_pkg::DV_Y: w_sum_sel = r_sy;
            default:       w_sum_sel = r_sz;
        endcase
        w_num = NUMW'(w_sum_sel) <<< FRAC_BITS;
        w_mag = w_num[NUMW-1] ? NUMW'(-w_num) : NUMW'(w_num);
    end

    // One restoring divide step: shift in the next dividend bit, subtract if it fits.
    assign w_trial = {r_drem, r_dnum[DVW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});

    // Floor correction for a negative sum: round the magnitude quotient away from zero.
    assign w_qadj = r_dnum[CEW-1:0] + CEW'(r_dneg && (r_drem != '0));
    assign w_cent = r_dneg ? -$signed(w_qadj) : $signed(w_qadj);

    // Squarer operand: three centroid differences, then three point differences.
    always_comb begin
        w_src = r_qpass ? {r_pz, r_py, r_px} : r_rd;
        case (r_k)
            3'd0, 3'd3: begin
                w_sc = w_src[COORD_BITS-1:0];
                w_pc = r_px;
                w_cc = r_cx;
            end
            3'd1, 3'd4: begin
                w_sc = w_src[2*COORD_BITS-1:COORD_BITS];
                w_pc = r_py;
                w_cc = r_cy;
            end
            default: begin
                w_sc = w_src[PW-1:2*COORD_BITS];
                w_pc = r_pz;
                w_cc = r_cz;
            end
        endcase
        if (r_k < 3'd3) begin
            w_diff = (MW'(w_sc) <<< FRAC_BITS) - MW'(w_cc);
        end else begin
            w_diff = MW'(w_sc) - MW'(w_pc);
        end
        w_amag = w_diff[MW-1] ? MW'(-w_diff) : MW'(w_diff);
    end

    assign w_e = r_eacc + r_prod[NW-1:0];

    assign w_contained = ((r_op == pcs_pkg::OP_LINK) && (r_found || r_changed)) ||
                         ((r_op == pcs_pkg::OP_QUERY) && r_found);

    // Memory port control.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IW-1:0];
        w_wdata = {r_pz, r_py, r_px};
        if (r_state == pcs_pkg::ST_APPLY && r_op == pcs_pkg::OP_LINK && w_link_ok) begin
            w_we = 1'b1;
        end else if (r_state == pcs_pkg::ST_RWR) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = r_rd;
        end
        w_raddr = (r_state == pcs_pkg::ST_RRD) ? r_count[IW-1:0] : r_i;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = (r_count == '0) ? pcs_pkg::ST_APPLY : pcs_pkg::ST_SRD;
                end
            end
            pcs_pkg::ST_SRD:  n_state = pcs_pkg::ST_SCMP;
            pcs_pkg::ST_SCMP: begin
                if (w_match || w_last) begin
                    n_state = pcs_pkg::ST_APPLY;
                end else begin
                    n_state = pcs_pkg::ST_SRD;
                end
            end
            pcs_pkg::ST_APPLY: begin
                if (r_op == pcs_pkg::OP_REMOVE && r_found) begin
                    n_state = pcs_pkg::ST_RRD;
                end else begin
                    n_state = pcs_pkg::ST_CENT;
                end
            end
            pcs_pkg::ST_RRD:  n_state = pcs_pkg::ST_RWR;
            pcs_pkg::ST_RWR:  n_state = pcs_pkg::ST_CENT;
            pcs_pkg::ST_CENT: begin
                n_state = (r_count == '0) ? pcs_pkg::ST_WRD : pcs_pkg::ST_DIV;
            end
            pcs_pkg::ST_DIV: begin
                if (r_dcnt == DCW'(1)) begin
                    n_state = pcs_pkg::ST_DEND;
                end
            end
            pcs_pkg::ST_DEND: begin
                case (r_dsel)
                    pcs_pkg::DV_DEV: n_state = pcs_pkg::ST_DONE;
                    pcs_pkg::DV_Z:   n_state = pcs_pkg::ST_WRD;
                    default:         n_state = pcs_pkg::ST_CENT;
                endcase
            end
            pcs_pkg::ST_WRD:  n_state = pcs_pkg::ST_WMUL;
            pcs_pkg::ST_WMUL: begin
                if (r_k == 3'd5) begin
                    n_state = pcs_pkg::ST_WEND;
                end
            end
            pcs_pkg::ST_WEND: begin
                if (r_qpass) begin
                    n_state = (r_count == '0) ? pcs_pkg::ST_DONE : pcs_pkg::ST_DIV;
                end else begin
                    n_state = pcs_pkg::ST_WRD;
                end
            end
            pcs_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = pcs_pkg::ST_IDLE;
                end
            end
            default: n_state = pcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers: held count, sums and the output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_sz      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (r_state == pcs_pkg::ST_APPLY) begin
                case (r_op)
                    pcs_pkg::OP_LINK: begin
                        if (w_link_ok) begin
                            r_count <= r_count + CW'(1);
                            r_sx    <= r_sx + SW'(r_px);
                            r_sy    <= r_sy + SW'(r_py);
                            r_sz    <= r_sz + SW'(r_pz);
                        end
                    end
                    pcs_pkg::OP_REMOVE: begin
                        if (r_found) begin
                            r_count <= r_count - CW'(1);
                            r_sx    <= r_sx - SW'(r_px);
                            r_sy    <= r_sy - SW'(r_py);
                            r_sz    <= r_sz - SW'(r_pz);
                        end
                    end
                    pcs_pkg::OP_CLEAR: begin
                        r_count <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sz    <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_state == pcs_pkg::ST_DONE && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            pcs_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    r_op      <= pcs_pkg::t_op'(i_s_tuser);
                    r_px      <= i_s_tdata[COORD_BITS-1:0];
                    r_py      <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
                    r_pz      <= i_s_tdata[PW-1:2*COORD_BITS];
                    r_i       <= '0;
                    r_found   <= 1'b0;
                    r_changed <= 1'b0;
                    r_qpass   <= 1'b0;
                    r_dsel    <= pcs_pkg::DV_X;
                    r_cx      <= '0;
                    r_cy      <= '0;
                    r_cz      <= '0;
                    r_disp    <= '0;
                    r_dev     <= '0;
                    r_mn      <= '0;
                    r_mx      <= '0;
                    r_near    <= '1;
                end
            end
            pcs_pkg::ST_SCMP: begin
                if (w_match) begin
                    r_found <= 1'b1;
                    r_idx   <= r_i;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
            pcs_pkg::ST_APPLY: begin
                if ((r_op == pcs_pkg::OP_LINK && w_link_ok) ||
                    (r_op == pcs_pkg::OP_REMOVE && r_found)) begin
                    r_changed <= 1'b1;
                end
            end
            pcs_pkg::ST_CENT: begin
                // Load a centroid divide; an empty set goes straight to the query pass.
                if (r_count == '0) begin
                    r_qpass <= 1'b1;
                end else begin
                    r_dnum <= DVW'(w_mag);
                    r_dneg <= w_num[NUMW-1];
                    r_drem <= '0;
                    r_dcnt <= DCW'(DVW);
                end
            end
            pcs_pkg::ST_DIV: begin
                r_dnum <= {r_dnum[DVW-2:0], w_ge};
                r_drem <= w_ge ? CW'(w_trial - {1'b0, r_count}) : w_trial[CW-1:0];
                r_dcnt <= r_dcnt - DCW'(1);
            end
            pcs_pkg::ST_DEND: begin
                case (r_dsel)
                    pcs_pkg::DV_X: r_cx <= w_cent;
                    pcs_pkg::DV_Y: r_cy <= w_cent;
                    pcs_pkg::DV_Z: r_cz <= w_cent;
                    default:       r_dev <= r_dnum[DW-1:0];
                endcase
                if (r_dsel == pcs_pkg::DV_Z) begin
                    r_i <= '0;
                end
                if (r_dsel != pcs_pkg::DV_DEV) begin
                    r_dsel <= pcs_pkg::t_div_sel'(r_dsel + 2'd1);
                end
            end
            pcs_pkg::ST_WRD: begin
                r_dacc <= '0;
                r_eacc <= '0;
                r_k    <= '0;
            end
            pcs_pkg::ST_WMUL: begin
                r_prod <= DW'(w_amag) * DW'(w_amag);
                if (r_k inside {[3'd1:3'd3]}) begin
                    r_dacc <= r_dacc + r_prod;
                end else if (r_k inside {[3'd4:3'd5]}) begin
                    r_eacc <= r_eacc + r_prod[NW-1:0];
                end
                r_k <= r_k + 3'd1;
            end
            pcs_pkg::ST_WEND: begin
                if (r_qpass) begin
                    // Query point done; start the mean divide when points are held.
                    r_qd   <= r_dacc;
                    r_dnum <= DVW'(r_disp);
                    r_dneg <= 1'b0;
                    r_drem <= '0;
                    r_dcnt <= DCW'(DVW);
                    r_dsel <= pcs_pkg::DV_DEV;
                end else begin
                    r_disp <= r_disp + DISPW'(r_dacc);
                    if (r_i == '0 || r_dacc < r_mn) begin
                        r_mn <= r_dacc;
                    end
                    if (r_i == '0 || r_dacc > r_mx) begin
                        r_mx <= r_dacc;
                    end
                    if (w_e < r_near) begin
                        r_near <= w_e;
                    end
                    if (w_last) begin
                        r_qpass <= 1'b1;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
            end
            pcs_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    r_mdata <= OUTB'({r_changed, w_contained, r_qd, r_near, r_mx, r_mn,
                                      r_dev, r_disp, r_cz, r_cy, r_cx, r_count});
                end
            end
            default: ;
        endcase
    end

`include "point_cluster_statistics_top_assert.svh"

    `PCS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `PCS_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `PCS_ASSERT_IMP(a_write_phase, i_clk, i_rst_n, w_we,
                    r_state == pcs_pkg::ST_APPLY || r_state == pcs_pkg::ST_RWR)
    `PCS_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, r_state != pcs_pkg::ST_APPLY, r_count == $past(r_count))

endmodule
